// ----- rtl/wfmj_pkg.sv -----
// ============================================================================
// wfmj_pkg
// Shared types and constants for the windowed feature match join block.
// ============================================================================
package wfmj_pkg;

    // Field widths of the stream payloads and configuration registers.
    localparam int FEAT_W       = 16;
    localparam int NUM_FEAT_IN  = 4;
    localparam int IN_DATA_W    = FEAT_W * NUM_FEAT_IN;
    localparam int WIN_W        = 17;
    localparam int FIU_W        = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = WIN_W;
    localparam int OUT_IDX_W    = 6;
    localparam int OUT_MASK_W   = 64;
    localparam int OUT_DATA_W   = 72;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_0        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FEATURES_IN_USE = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic ptr_end;
        logic rd_pend;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/wfmj_ctrl.sv -----
// ============================================================================
// wfmj_ctrl
// Sequencer that accepts a row, steps the store scan and commits the result.
// ============================================================================
module wfmj_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  wfmj_pkg::t_dp_sts  i_sts,
    output wfmj_pkg::t_dp_cmd  o_cmd
);
    import wfmj_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one store read per cycle, then let the last compare drain.
                if (!i_sts.full && !i_sts.ptr_end) begin
                    o_cmd.rd_step = 1'b1;
                end else if (!i_sts.rd_pend) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/wfmj_dp.sv -----
// ============================================================================
// wfmj_dp
// Row store, window compare unit, match mask and output register.
// ============================================================================
module wfmj_dp #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_FEATURES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wfmj_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wfmj_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [wfmj_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [wfmj_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser,
    input  wfmj_pkg::t_dp_cmd                 i_cmd,
    output wfmj_pkg::t_dp_sts                 o_sts
);
    import wfmj_pkg::*;

    localparam int ROW_W = MAX_FEATURES * FEAT_W;
    localparam int IW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_ROWS + 1);

    // Configuration registers.
    logic [WIN_W-1:0] r_win [MAX_FEATURES];
    logic [FIU_W-1:0] r_fiu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < MAX_FEATURES; f++) begin
                r_win[f] <= '0;
            end
            r_fiu <= FIU_W'(1);
        end else if (i_cfg_we) begin
            for (int f = 0; f < MAX_FEATURES; f++) begin
                if (i_cfg_addr == REG_WINDOW_0 + CFG_ADDR_W'(f)) begin
                    r_win[f] <= i_cfg_wdata;
                end
            end
            if (i_cfg_addr == REG_FEATURES_IN_USE) begin
                r_fiu <= i_cfg_wdata[FIU_W-1:0];
            end
        end
    end

    logic [FIU_W-1:0] w_used;
    assign w_used = (r_fiu > FIU_W'(MAX_FEATURES)) ? FIU_W'(MAX_FEATURES) : r_fiu;

    // Row under test, row count and scan pointer.
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_ptr;

    logic w_full;
    assign w_full = (r_count == CW'(MAX_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr <= '0;
                if (i_s_tuser) begin
                    r_count <= '0;
                end
            end else if (i_cmd.rd_step) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.commit && !w_full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= i_s_tdata[ROW_W-1:0];
        end
    end

    // Row store with a registered read port.
    logic [ROW_W-1:0] r_mem [MAX_ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic [IW-1:0]    r_rd_idx;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !w_full) begin
            r_mem[r_count[IW-1:0]] <= r_row;
        end
        if (i_cmd.rd_step) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_step) begin
            r_rd_idx <= r_ptr[IW-1:0];
        end
    end

    // Window compare of the fetched row against the row under test.
    logic [FEAT_W-1:0] w_diff [MAX_FEATURES];
    logic              w_match;

    always_comb begin
        for (int f = 0; f < MAX_FEATURES; f++) begin
            if (r_row[f*FEAT_W +: FEAT_W] >= r_rd_data[f*FEAT_W +: FEAT_W]) begin
                w_diff[f] = r_row[f*FEAT_W +: FEAT_W] - r_rd_data[f*FEAT_W +: FEAT_W];
            end else begin
                w_diff[f] = r_rd_data[f*FEAT_W +: FEAT_W] - r_row[f*FEAT_W +: FEAT_W];
            end
        end
    end

    always_comb begin
        w_match = 1'b1;
        for (int f = 0; f < MAX_FEATURES; f++) begin
            if (FIU_W'(f) < w_used) begin
                if (r_win[f][WIN_W-1]) begin
                    // A negative window only asks for the codes to differ.
                    if (w_diff[f] == '0) begin
                        w_match = 1'b0;
                    end
                end else if ({1'b0, w_diff[f]} > r_win[f]) begin
                    w_match = 1'b0;
                end
            end
        end
    end

    logic [OUT_MASK_W-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask <= '0;
        end else if (r_rd_vld && w_match) begin
            r_mask[r_rd_idx] <= 1'b1;
        end
    end

    // Output register.
    logic                  r_out_vld;
    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic [OUT_MASK_W-1:0] r_out_mask;
    logic                  r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_full <= w_full;
            if (w_full) begin
                r_out_idx  <= '0;
                r_out_mask <= '0;
            end else begin
                r_out_idx  <= OUT_IDX_W'(r_count);
                r_out_mask <= r_mask;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_MASK_W - OUT_IDX_W){1'b0}}, r_out_mask, r_out_idx};
    assign o_m_tuser  = r_out_full;

    assign o_sts.full     = w_full;
    assign o_sts.ptr_end  = (r_ptr == r_count);
    assign o_sts.rd_pend  = r_rd_vld;
    assign o_sts.out_free = !r_out_vld || i_m_tready;

endmodule

// ----- rtl/windowed_feature_match_join.sv -----
// ============================================================================
// windowed_feature_match_join
// Stores feature rows and reports which earlier rows fall inside the windows.
// ============================================================================
// Usage:
// Each transfer on the slave stream carries one row of four 16-bit feature
// codes; tuser set marks the row as the first of a new data set (index 0).
// The block compares the row with every row stored earlier in the data set,
// one store read per cycle, and returns one transfer on the master stream
// with the row index and a mask of the matching earlier rows. When the store
// already holds MAX_ROWS rows, the row is dropped and tuser flags it.
// Windows and the number of compared features are written through the
// configuration port; the user must write them only while the block is
// idle, which the block does not enforce. After acceptance the block
// scans the stored rows in order through the single read port of the
// row store, lets the last compare drain and commits; an empty store, a
// restart or a full store skips the scan. One row is in work at a time,
// and the next row is taken in the cycle after the result is registered.
// Reset clears the row count, the windows (to zero) and the feature count
// (to one); store contents stay undefined until written. If the receiver
// stalls, the result waits in the output register while the next row is
// accepted and scanned; that row then waits to commit until the register
// is free.
// ============================================================================
module windowed_feature_match_join #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_FEATURES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [wfmj_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wfmj_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input rows.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // From bit 0: feature_0, feature_1, feature_2, feature_3.
    input  logic [wfmj_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // restart.
    input  logic                              s_axis_tuser,
    // Results.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // From bit 0: row_index (6), match_mask (64), zero padding (2).
    output logic [wfmj_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // store_full.
    output logic                              m_axis_tuser
);
    import wfmj_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller only sequences; all storage and arithmetic live in the
    // datapath.
    wfmj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wfmj_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    // A rejected row carries neither an index nor any match bit.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected row carries index or mask bits");

    // Only earlier rows can match: no mask bit at or above the row index.
    a_mask_below_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[OUT_IDX_W +: OUT_MASK_W] >> m_axis_tdata[OUT_IDX_W-1:0]) == '0))
        else $error("match mask has a bit at or above the row index");

    // One row at a time: the input is closed in the cycle after an accepted transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a row is in work");

endmodule

// ----- tb/wfmj_join_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// wfmj_join_checker
// Watches the configuration port and both streams of the windowed feature
// match join, keeps its own copy of the windows and the stored rows, predicts
// the result of every accepted row and compares it with what comes out.
// ============================================================================
module wfmj_join_checker #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_FEATURES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wfmj_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wfmj_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // From bit 0: feature_0, feature_1, feature_2, feature_3.
    input  logic [wfmj_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // restart.
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // From bit 0: row_index, match_mask, zero padding.
    input  logic [wfmj_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // store_full.
    input  logic                            i_m_tuser,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_full_hits,
    output int                              o_match_hits
);
    import wfmj_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  row_index;
        logic [OUT_MASK_W-1:0] match_mask;
        logic                  store_full;
    } t_join_result;

    logic signed [WIN_W-1:0] window [NUM_FEAT_IN];
    logic [FIU_W-1:0]        feat_count;
    logic [IN_DATA_W-1:0]    row_mem [MAX_ROWS];
    int                      rows_held;
    t_join_result            awaited_q [$];

    // A negative window only asks the codes to differ.
    function automatic bit rows_agree(logic [IN_DATA_W-1:0] a, logic [IN_DATA_W-1:0] b,
                                      int used);
        logic [FEAT_W-1:0] va;
        logic [FEAT_W-1:0] vb;
        logic [FEAT_W:0]   gap;
        for (int f = 0; f < used; f++) begin
            va  = a[f*FEAT_W +: FEAT_W];
            vb  = b[f*FEAT_W +: FEAT_W];
            gap = (va > vb) ? {1'b0, va - vb} : {1'b0, vb - va};
            if (window[f][WIN_W-1]) begin
                if (gap == 0) return 1'b0;
            end else if (gap > window[f]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Works out the result of one row and appends the row to the store unless it is full.
    function automatic t_join_result predict_join(logic restart, logic [IN_DATA_W-1:0] row);
        t_join_result res;
        int           used;
        res = '0;
        if (restart) rows_held = 0;
        used = (feat_count > MAX_FEATURES) ? MAX_FEATURES : int'(feat_count);
        if (rows_held >= MAX_ROWS) begin
            res.store_full = 1'b1;
            return res;
        end
        for (int j = 0; j < rows_held; j++) begin
            if (rows_agree(row, row_mem[j], used)) res.match_mask[j] = 1'b1;
        end
        res.row_index      = rows_held[OUT_IDX_W-1:0];
        row_mem[rows_held] = row;
        rows_held          = rows_held + 1;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_join_result got;
        t_join_result want;
        int           slot;
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FEAT_IN; f++) window[f] = '0;
            feat_count   = FIU_W'(1);
            rows_held    = 0;
            awaited_q.delete();
            o_errors     = 0;
            o_checked    = 0;
            o_full_hits  = 0;
            o_match_hits = 0;
        end else begin
            if (i_cfg_we) begin
                slot = int'(i_cfg_addr) - int'(REG_WINDOW_0);
                if (i_cfg_addr == REG_FEATURES_IN_USE)
                    feat_count = i_cfg_wdata[FIU_W-1:0];
                else if (slot >= 0 && slot < NUM_FEAT_IN)
                    window[slot] = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.row_index  = i_m_tdata[OUT_IDX_W-1:0];
                got.match_mask = i_m_tdata[OUT_IDX_W +: OUT_MASK_W];
                got.store_full = i_m_tuser;
                if (awaited_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with nothing awaited: index %0d mask %h full %b",
                             $time, got.row_index, got.match_mask, got.store_full);
                end else begin
                    want = awaited_q.pop_front();
                    o_checked++;
                    if (got.store_full) o_full_hits++;
                    if (got.match_mask != 0) o_match_hits++;
                    if (got.row_index != want.row_index) begin
                        o_errors++;
                        $display("%0t: row_index expected %0d, actual %0d",
                                 $time, want.row_index, got.row_index);
                    end
                    if (got.match_mask != want.match_mask) begin
                        o_errors++;
                        $display("%0t: match_mask expected %h, actual %h",
                                 $time, want.match_mask, got.match_mask);
                    end
                    if (got.store_full != want.store_full) begin
                        o_errors++;
                        $display("%0t: store_full expected %b, actual %b",
                                 $time, want.store_full, got.store_full);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_q.insert(awaited_q.size(), predict_join(i_s_tuser, i_s_tdata));
        end
        o_pending = awaited_q.size();
    end

endmodule

// ----- tb/windowed_feature_match_join_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// windowed_feature_match_join_tb
// Drives rows of feature codes into the match join under many window
// settings and lets a checker beside the block compare every result.
// ============================================================================
module windowed_feature_match_join_tb;
    import wfmj_pkg::*;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_FEATURES = 4;
    // Longest scan plus pipeline, with margin, before touching registers.
    localparam int SETTLE       = MAX_ROWS + 16;
    localparam int RANDOM_ROWS  = 850;
    localparam int LIMIT        = 600_000;
    // An index past the register list; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_tvalid      = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata       = '0;
    logic                  s_tuser       = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready      = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int errors;
    int pending;
    int checked;
    int full_hits;
    int match_hits;

    // While calm is set neither side inserts bubbles or stalls.
    logic calm        = 1'b0;
    int   cycle_count = 0;
    int   rows_sent   = 0;
    int   data_sets   = 0;
    int   settings    = 0;

    // Windows staged here before a register programming pass.
    logic [WIN_W-1:0] win_plan [NUM_FEAT_IN];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    windowed_feature_match_join #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_FEATURES(MAX_FEATURES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser)
    );

    wfmj_join_checker #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_FEATURES(MAX_FEATURES)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_hits (full_hits),
        .o_match_hits(match_hits)
    );

    // The receiver stalls at random about twelve percent of the time, except
    // during the calm stretch where it takes every result at once.
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("windowed_feature_match_join_tb: errors");
            $finish;
        end
    end

    // Offers one row and returns at the edge where it was taken. The valid
    // is left high so that a following row can go out back to back; any
    // bubble is inserted at the start of the next call. The ready is sampled
    // at the falling edge, where it is settled for the coming rising edge.
    task automatic push_row(input logic restart, input logic [IN_DATA_W-1:0] row);
        while (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tuser  <= restart;
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        rows_sent++;
        if (restart) data_sets++;
    endtask

    // Drops the valid, waits for every awaited result, then lets the block
    // finish any scan still running before registers may change.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes all four windows from win_plan and the feature count. The upper
    // bits of the feature count write carry junk, which the block must drop.
    // Optionally the spare index is hit as well.
    task automatic program_windows(input logic [FIU_W-1:0] feat_used, input bit poke_spare);
        for (int f = 0; f < NUM_FEAT_IN; f++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_WINDOW_0 + CFG_ADDR_W'(f);
            cfg_wdata <= win_plan[f];
            @(posedge i_clk);
        end
        cfg_addr  <= REG_FEATURES_IN_USE;
        cfg_wdata <= {14'($urandom), feat_used};
        @(posedge i_clk);
        if (poke_spare) begin
            cfg_addr  <= REG_SPARE;
            cfg_wdata <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Windows lean toward the interesting values: the must-differ code, other
    // negative codes, zero, the widest window and small distances.
    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return {1'b1, 16'($urandom)};
            2:       return '0;
            3:       return 17'd65535;
            4:       return 17'($urandom_range(0, 65535));
            default: return 17'($urandom_range(0, 6));
        endcase
    endfunction

    // Clustered rows sit near a base so that small windows give matches;
    // the other styles reach the extremes and every bit of each code.
    function automatic logic [IN_DATA_W-1:0] make_row(int style, logic [IN_DATA_W-1:0] base);
        logic [IN_DATA_W-1:0] row;
        for (int f = 0; f < NUM_FEAT_IN; f++) begin
            if (style <= 6)
                row[f*FEAT_W +: FEAT_W] = base[f*FEAT_W +: FEAT_W] + 16'($urandom_range(0, 6));
            else if (style == 7)
                case ($urandom_range(0, 2))
                    0:       row[f*FEAT_W +: FEAT_W] = '0;
                    1:       row[f*FEAT_W +: FEAT_W] = '1;
                    default: row[f*FEAT_W +: FEAT_W] = base[f*FEAT_W +: FEAT_W];
                endcase
            else
                row[f*FEAT_W +: FEAT_W] = 16'($urandom);
        end
        return row;
    endfunction

    initial begin : stimulus
        int                   phase;
        int                   set_count;
        int                   set_size;
        int                   style;
        int                   target;
        logic [IN_DATA_W-1:0] base;
        logic [FIU_W-1:0]     feat_used;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ----
        // Reset settings: zero windows, one feature compared. Identical codes
        // match, the full-scale code only matches its equal.
        push_row(1'b1, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        push_row(1'b0, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        push_row(1'b0, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
        push_row(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});

        // Widest window, must-differ, zero window and a negative window other
        // than minus one; a feature count of seven saturates to four.
        drain();
        win_plan[0] = 17'd65535;
        win_plan[1] = '1;
        win_plan[2] = '0;
        win_plan[3] = 17'h10000;
        program_windows(3'd7, 1'b1);
        push_row(1'b1, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        push_row(1'b0, {16'h0005, 16'h0000, 16'h0001, 16'hFFFF});
        push_row(1'b0, {16'h0005, 16'h0000, 16'h0001, 16'h1234});
        push_row(1'b0, {16'h0000, 16'h0000, 16'h0000, 16'h0000});

        // No feature compared: every earlier row matches.
        drain();
        program_windows(3'd0, 1'b0);
        push_row(1'b1, {16'h1111, 16'h2222, 16'h3333, 16'h4444});
        push_row(1'b0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        push_row(1'b0, 64'($urandom) | (64'($urandom) << 32));

        // All four features with a distance of two, then a restart in the
        // middle of a data set, which must give index zero and no matches.
        drain();
        for (int f = 0; f < NUM_FEAT_IN; f++) win_plan[f] = 17'd2;
        program_windows(3'd4, 1'b0);
        push_row(1'b1, {16'd100, 16'd100, 16'd100, 16'd100});
        push_row(1'b0, {16'd100, 16'd101, 16'd98,  16'd102});
        push_row(1'b0, {16'd100, 16'd100, 16'd100, 16'd103});
        push_row(1'b1, {16'd100, 16'd100, 16'd100, 16'd100});
        push_row(1'b0, {16'd100, 16'd100, 16'd100, 16'd100});

        // ---- Random part ----
        // Each phase picks new registers and sends a few data sets. Every
        // fourth phase opens with a set longer than the store, so rows get
        // rejected as full and the rejection persists until a restart.
        target = rows_sent + RANDOM_ROWS;
        phase  = 0;
        while (rows_sent < target) begin
            phase++;
            drain();
            for (int f = 0; f < NUM_FEAT_IN; f++) win_plan[f] = pick_window();
            case ($urandom_range(0, 9))
                0:       feat_used = 3'd0;
                1:       feat_used = 3'($urandom_range(5, 7));
                default: feat_used = 3'($urandom_range(1, 4));
            endcase
            program_windows(feat_used, $urandom_range(0, 3) == 0);
            calm <= (phase >= 4 && phase <= 6);

            set_count = $urandom_range(2, 5);
            for (int s = 0; s < set_count; s++) begin
                if (s == 0 && phase % 4 == 1)
                    set_size = MAX_ROWS + $urandom_range(1, 5);
                else
                    set_size = $urandom_range(1, 24);
                style = $urandom_range(0, 9);
                base  = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
                // Mostly a clean restart per set; now and then a set runs on
                // from the previous one or restarts midway.
                for (int r = 0; r < set_size; r++) begin
                    push_row((r == 0) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 49) == 0),
                             make_row(style, base));
                end
            end
        end

        drain();
        $display("Covered %0d rows in %0d restarted data sets over %0d register settings.",
                 rows_sent, data_sets, settings);
        $display("Checked %0d results: %0d with matches, %0d rejected as store full.",
                 checked, match_hits, full_hits);
        if (errors == 0) begin
            $display("windowed_feature_match_join_tb: clean");
        end else begin
            $display("windowed_feature_match_join_tb: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/wfmj_pkg.sv
rtl/wfmj_ctrl.sv
rtl/wfmj_dp.sv
rtl/windowed_feature_match_join.sv
tb/wfmj_join_checker.sv
tb/windowed_feature_match_join_tb.sv
